[hw/rtl/sfmt_pkg.sv]
// Shared constants, types and the channel-status table for the S/PDIF subframe formatter.
`default_nettype none
package sfmt_pkg;

    localparam int NumChannelsDefault = 2;

    localparam int SampleW  = 32;
    localparam int WordW    = 32;
    localparam int CountW   = 8;
    localparam int ModeW    = 2;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 2;

    localparam logic [CountW-1:0] BlockLast = CountW'(191);

    // item modes
    localparam logic [ModeW-1:0] MODE_FORMAT  = 2'd0;
    localparam logic [ModeW-1:0] MODE_MUTE    = 2'd1;
    localparam logic [ModeW-1:0] MODE_RESTART = 2'd2;

    // sample formats; the other codes behave as 32-bit
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RATE_CODE     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STATUS_ENABLE = 2'd2;

    localparam logic [1:0] RATE_RESET = 2'd1;

    localparam logic [WordW-1:0] MUTE_WORD = '1;

    // byte 3 flag bits
    localparam logic [7:0] MARK_BLOCK = 8'h30;
    localparam logic [7:0] MARK_FRAME = 8'h10;
    localparam logic [7:0] STATUS_BIT = 8'h04;
    localparam logic [7:0] PARITY_BIT = 8'h08;

    // counter control passed to the frame counter bank
    typedef struct packed {
        logic advance;
        logic restart;
    } t_ctr_ctl;

    // per-channel, per-rate channel-status pattern; bit n set = frame n carries a 1
    function automatic logic [63:0] status_mask(input logic ch, input logic [1:0] rate);
        logic [63:0] m;
        m = '0;
        case ({ch, rate})
            3'b000:  m = 64'h0000_000B_0010_0004;
            3'b001:  m = 64'h0000_000B_0210_0004;
            3'b010:  m = 64'h0000_000B_0810_0004;
            3'b011:  m = 64'h0000_000B_0A10_0004;
            3'b100:  m = 64'h0000_000B_0020_0004;
            3'b101:  m = 64'h0000_000B_0220_0004;
            3'b110:  m = 64'h0000_000B_0820_0004;
            3'b111:  m = 64'h0000_000B_0A20_0004;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sfmt_frame_ctr.sv]
// Per-channel frame counters, wrapping at the end of a 192-frame block.
`default_nettype none
module sfmt_frame_ctr
    import sfmt_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDefault,
    localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctr_ctl          i_ctl,
    input  wire logic [ChW-1:0]    i_ch,
    output logic      [CountW-1:0] o_idx
);

    logic [CountW-1:0] r_cnt [NUM_CHANNELS];
    logic [CountW-1:0] n_cnt;

    assign o_idx = r_cnt[i_ch];
    assign n_cnt = (o_idx == BlockLast) ? '0 : o_idx + CountW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_ctl.advance) begin
            r_cnt[i_ch] <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sfmt_encode.sv]
// Builds the device word: byte selection, channel-status bit, parity and block markers.
`default_nettype none
module sfmt_encode
    import sfmt_pkg::*;
(
    input  wire logic [SampleW-1:0] i_sample,
    input  wire logic [1:0]         i_fmt,
    input  wire logic [1:0]         i_rate,
    input  wire logic               i_status_en,
    input  wire logic               i_ch,
    input  wire logic [CountW-1:0]  i_idx,
    output logic      [WordW-1:0]   o_word
);

    logic [23:0] audio;
    logic [63:0] mask;
    logic        stat;
    logic        par;
    logic [7:0]  b3;

    always_comb begin
        case (i_fmt)
            FMT_16:  audio = {i_sample[15:0], 8'h00};
            FMT_24:  audio = i_sample[23:0];
            default: audio = i_sample[31:8];
        endcase
    end

    assign mask = status_mask(i_ch, i_rate);
    // frames past 63 never carry status
    assign stat = i_status_en && (i_idx[7:6] == 2'b00) && mask[i_idx[5:0]];
    assign par  = ^{audio, stat};

    always_comb begin
        b3 = '0;
        if (stat) b3 = b3 | STATUS_BIT;
        if (par)  b3 = b3 | PARITY_BIT;
        if (!i_ch) b3 = b3 | ((i_idx == '0) ? MARK_BLOCK : MARK_FRAME);
    end

    assign o_word = {b3, audio};

endmodule
`default_nettype wire

[hw/rtl/spdif_subframe_formatter.sv]
// S/PDIF subframe formatter top level: configuration registers, counters and output skid.
// One beat in, at most one beat out, one item per clock sustained while i_out_stall is low.
// Each sample is formatted in the accepting cycle from the per-channel frame counter and lands
// in the result register; a skid stage behind it absorbs one extra word while that register
// is held, and o_in_stall rises only while the skid is occupied. Mute beats give an all-ones
// word without moving the counters, restart beats clear all counters and give no word, and
// mode 3 is dropped. Configuration writes take effect on the next beat.
`default_nettype none
module spdif_subframe_formatter
    import sfmt_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ModeW-1:0]    i_mode,
    input  wire logic                i_channel,
    input  wire logic [SampleW-1:0]  i_sample,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [WordW-1:0]    o_word,
    output logic                     o_out_channel
);

    localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [1:0] r_fmt;
    logic [1:0] r_rate;
    logic       r_stat_en;

    logic              in_acc;
    logic              res_vld;
    t_ctr_ctl          ctl;
    logic [CountW-1:0] idx;
    logic [WordW-1:0]  enc_word;
    logic [WordW-1:0]  n_word;
    logic              out_take;

    logic             r_main_vld;
    logic [WordW-1:0] r_main_word;
    logic             r_main_ch;
    logic             r_skid_vld;
    logic [WordW-1:0] r_skid_word;
    logic             r_skid_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_16;
            r_rate    <= RATE_RESET;
            r_stat_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_FORMAT: r_fmt     <= i_cfg_data;
                CFG_RATE_CODE:     r_rate    <= i_cfg_data;
                CFG_STATUS_ENABLE: r_stat_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_skid_vld;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign res_vld    = in_acc && (i_mode == MODE_FORMAT || i_mode == MODE_MUTE);

    assign ctl.advance = in_acc && (i_mode == MODE_FORMAT);
    assign ctl.restart = in_acc && (i_mode == MODE_RESTART);

    sfmt_frame_ctr #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_ch   (ChW'(i_channel)),
        .o_idx  (idx)
    );

    sfmt_encode u_enc (
        .i_sample   (i_sample),
        .i_fmt      (r_fmt),
        .i_rate     (r_rate),
        .i_status_en(r_stat_en),
        .i_ch       (i_channel),
        .i_idx      (idx),
        .o_word     (enc_word)
    );

    assign n_word = (i_mode == MODE_MUTE) ? MUTE_WORD : enc_word;

    assign out_take = r_main_vld && !i_out_stall;

    // while the skid holds a beat no input is taken, so it drains first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (res_vld) begin
            if (!r_main_vld || out_take) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (out_take) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) begin
                r_main_word <= r_skid_word;
                r_main_ch   <= r_skid_ch;
            end
        end else if (res_vld) begin
            if (!r_main_vld || out_take) begin
                r_main_word <= n_word;
                r_main_ch   <= i_channel;
            end else begin
                r_skid_word <= n_word;
                r_skid_ch   <= i_channel;
            end
        end
    end

    assign o_out_valid   = r_main_vld;
    assign o_word        = r_main_word;
    assign o_out_channel = r_main_ch;

endmodule
`default_nettype wire

[sim/spdif_subframe_formatter_tb_pkg.sv]
// Word predictor and scoreboard for the S/PDIF subframe formatter testbench.
`timescale 1ns / 100ps
package spdif_subframe_formatter_tb_pkg;
    import sfmt_pkg::*;

    localparam logic [ModeW-1:0]   MODE_UNUSED = 2'd3;
    localparam logic [1:0]         FMT_32      = 2'd2;
    localparam logic [1:0]         FMT_ALIAS   = 2'd3;   // spare code, behaves as 32-bit
    localparam logic [1:0]         RATE_44K1   = 2'd0;
    localparam logic [1:0]         RATE_48K    = 2'd1;
    localparam logic [1:0]         RATE_88K2   = 2'd2;
    localparam logic [1:0]         RATE_96K    = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED  = 2'd3;

    typedef struct {
        logic [WordW-1:0] word;
        logic             ch;
    } t_subframe;

    class subframe_predictor;
        t_subframe         expected_words[$];
        logic [1:0]        fmt;
        logic [1:0]        rate;
        logic              status_en;
        logic [CountW-1:0] frame_idx[2];
        bit                wrapped;
        int                errors;

        function new();
            fmt          = FMT_16;
            rate         = RATE_RESET;
            status_en    = 1'b1;
            frame_idx[0] = '0;
            frame_idx[1] = '0;
            wrapped      = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
            case (idx)
                CFG_SAMPLE_FORMAT: fmt = data;
                CFG_RATE_CODE:     rate = data;
                CFG_STATUS_ENABLE: status_en = data[0];
                default: ;
            endcase
        endfunction

        // frames 2, 32, 33, 35 always; 20 or 21 by channel; 25 and 27 by rate
        function bit status_bit(input logic ch, input logic [CountW-1:0] frame);
            case (frame)
                8'd2, 8'd32, 8'd33, 8'd35: return 1'b1;
                8'd20:   return !ch;
                8'd21:   return ch;
                8'd25:   return rate == RATE_48K || rate == RATE_96K;
                8'd27:   return rate == RATE_88K2 || rate == RATE_96K;
                default: return 1'b0;
            endcase
        endfunction

        function void note_beat(input logic [ModeW-1:0] mode, input logic ch,
                                input logic [SampleW-1:0] sample);
            t_subframe         w;
            logic [23:0]       audio;
            logic [7:0]        flags;
            logic [CountW-1:0] idx;
            case (mode)
                MODE_RESTART: begin
                    frame_idx[0] = '0;
                    frame_idx[1] = '0;
                end
                MODE_MUTE: begin
                    w.word = MUTE_WORD;
                    w.ch   = ch;
                    expected_words.push_back(w);
                end
                MODE_FORMAT: begin
                    case (fmt)
                        FMT_16:  audio = {sample[15:0], 8'h00};
                        FMT_24:  audio = sample[23:0];
                        default: audio = sample[31:8];
                    endcase
                    idx   = frame_idx[ch];
                    flags = (status_en && status_bit(ch, idx)) ? STATUS_BIT : 8'h00;
                    // even parity over the audio bytes and the status bit
                    if (^{audio, flags})
                        flags |= PARITY_BIT;
                    if (!ch)
                        flags |= (idx == 0) ? MARK_BLOCK : MARK_FRAME;
                    if (idx == BlockLast) begin
                        frame_idx[ch] = '0;
                        wrapped       = 1'b1;
                    end else begin
                        frame_idx[ch] = idx + 1'b1;
                    end
                    w.word = {flags, audio};
                    w.ch   = ch;
                    expected_words.push_back(w);
                end
                default: ;
            endcase
        endfunction

        function void check_word(input logic [WordW-1:0] word, input logic ch);
            t_subframe w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h on channel %0d", $time, word, ch);
                return;
            end
            w = expected_words.pop_front();
            if (word !== w.word) begin
                errors++;
                $display("%0t: word expected %h, got %h", $time, w.word, word);
            end
            if (ch !== w.ch) begin
                errors++;
                $display("%0t: channel expected %0d, got %0d", $time, w.ch, ch);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

[sim/spdif_subframe_formatter_tb.sv]
// Testbench top for the S/PDIF subframe formatter: stimulus, stall patterns and checking.
`timescale 1ns / 100ps
module spdif_subframe_formatter_tb;
    import sfmt_pkg::*;
    import spdif_subframe_formatter_tb_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 500;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_pattern;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic [ModeW-1:0]    i_mode      = MODE_FORMAT;
    logic                i_channel   = 1'b0;
    logic [SampleW-1:0]  i_sample    = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [WordW-1:0]    o_word;
    logic                o_out_channel;

    subframe_predictor board;
    logic              hold_req    = 1'b0;
    bit                gaps_on     = 1'b1;
    int                burst_left  = 0;
    int                idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    spdif_subframe_formatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_word        (o_word),
        .o_out_channel (o_out_channel)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall)
                board.check_word(o_word, o_out_channel);
            if (i_in_valid && !o_in_stall)
                board.note_beat(i_mode, i_channel, i_sample);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("spdif_subframe_formatter verification failed");
            $finish;
        end
    end

    // output side: changing stall patterns, plus one long hold-off on request
    initial begin
        int             seg_left;
        int             hold_left;
        t_stall_pattern pattern;
        seg_left  = 0;
        hold_left = 0;
        pattern   = STALL_NONE;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0) begin
                pattern  = t_stall_pattern'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (pattern)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 9) < 3);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default:     i_out_stall <= (seg_left % 4 == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic [ModeW-1:0] mode, input logic ch,
                             input logic [SampleW-1:0] sample);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_channel  <= ch;
        i_sample   <= sample;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // wait until every word is out, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] fmt, input logic [1:0] rate, input logic en);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SAMPLE_FORMAT;
        i_cfg_data  <= fmt;
        @(posedge i_clk);
        i_cfg_index <= CFG_RATE_CODE;
        i_cfg_data  <= rate;
        @(posedge i_clk);
        i_cfg_index <= CFG_STATUS_ENABLE;
        i_cfg_data  <= {1'b0, en};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SampleW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // mostly alternating channel frames; mutes, restarts and spare-mode beats mixed in
    task automatic run_frames(input int length, inout int sent);
        logic ch;
        int   kind;
        int   done;
        ch   = 1'($urandom_range(0, 1));
        done = 0;
        while (done < length) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                send_beat(MODE_UNUSED, 1'($urandom_range(0, 1)), $urandom());
            end else begin
                if (kind < 5 && board.wrapped)
                    send_beat(MODE_RESTART, ch, pick_sample());
                else if (kind < 11)
                    send_beat(MODE_MUTE, ch, pick_sample());
                else
                    send_beat(MODE_FORMAT, ch, pick_sample());
                ch = ($urandom_range(0, 99) < 85) ? !ch : ch;
                done++;
            end
        end
        sent += done;
    endtask

    initial begin
        int sent;
        int seq;
        board = new();
        sent  = 0;
        seq   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 16-bit, 48k, status on
        send_beat(MODE_FORMAT, 1'b0, 32'h0000_0000);   // block start marker
        send_beat(MODE_FORMAT, 1'b1, 32'hFFFF_FFFF);
        send_beat(MODE_FORMAT, 1'b0, 32'h0000_8001);
        send_beat(MODE_FORMAT, 1'b1, 32'h0001_0000);   // upper bytes dropped
        send_beat(MODE_FORMAT, 1'b0, 32'h0000_0000);   // frame 2 carries a status bit
        send_beat(MODE_FORMAT, 1'b1, 32'h0000_00FF);
        send_beat(MODE_MUTE, 1'b0, 32'h0000_0000);
        send_beat(MODE_MUTE, 1'b1, 32'hFFFF_FFFF);
        send_beat(MODE_UNUSED, 1'b1, 32'hA5A5_5A5A);
        send_beat(MODE_RESTART, 1'b1, 32'h0000_0000);
        send_beat(MODE_FORMAT, 1'b0, 32'h0000_00FF);   // back at frame 0
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 2'b11;
        @(posedge i_clk);
        set_config(FMT_24, RATE_44K1, 1'b0);
        send_beat(MODE_FORMAT, 1'b0, 32'h00FF_FFFF);
        send_beat(MODE_FORMAT, 1'b1, 32'hFF80_0000);
        drain();
        set_config(FMT_32, RATE_96K, 1'b1);
        send_beat(MODE_FORMAT, 1'b0, 32'hFFFF_FF00);
        send_beat(MODE_FORMAT, 1'b1, 32'h0000_00FF);
        drain();
        set_config(FMT_ALIAS, RATE_88K2, 1'b1);
        send_beat(MODE_FORMAT, 1'b0, 32'h8000_0001);
        send_beat(MODE_FORMAT, 1'b1, 32'h7FFF_FFFE);

        while (sent < RANDOM_ITEMS) begin
            drain();
            set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       $urandom_range(0, 3) != 0);
            gaps_on = 1'b1;
            // back-to-back beats against a long output hold-off to fill the skid
            if (seq == 2) begin
                hold_req <= 1'b1;
                gaps_on  = 1'b0;
            end
            if (board.wrapped && $urandom_range(0, 1)) begin
                send_beat(MODE_RESTART, 1'b0, pick_sample());
                sent++;
            end
            run_frames($urandom_range(30, 70), sent);
            seq++;
        end
        drain();

        if (board.errors == 0)
            $display("spdif_subframe_formatter verification clean");
        else
            $display("spdif_subframe_formatter verification failed");
        $finish;
    end

endmodule
